[rtl/dn2cd_pkg.sv]
// Shared types, constants and tables for the day number to calendar date converter.
package dn2cd_pkg;

    localparam int DN_W    = 23;
    localparam int YEAR_W  = 15;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    localparam int Z_W     = 23;
    localparam int XA_W    = 24;
    localparam int ALPHA_W = 7;
    localparam int B_W     = 23;
    localparam int XC_W    = 27;
    localparam int C_W     = 15;
    localparam int BD_W    = 9;
    localparam int XE_W    = 23;
    localparam int E_W     = 5;

    localparam logic [DN_W-1:0] DAY_NUMBER_MAX  = 23'd5373483;
    localparam logic [Z_W-1:0]  GREGORIAN_START = 23'd2299161;

    localparam logic [XA_W-1:0] ALPHA_BIAS   = 24'd7468865;
    localparam int              ALPHA_DIV    = 146097;
    localparam logic [B_W-1:0]  B_OFFSET     = 23'd1524;
    localparam logic [XC_W-1:0] XC_BIAS      = 27'd2442;
    localparam int              C_DIV        = 7305;
    localparam logic [10:0]     DAYS_4Y      = 11'd1461;
    localparam logic [13:0]     E_SCALE      = 14'd10000;
    localparam int              E_DIV        = 306001;

    localparam logic [E_W-1:0]     E_YEAR_WRAP = 5'd14;
    localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd2;
    localparam logic [C_W:0]       YEAR_OFS_LO = 16'd4716;
    localparam logic [C_W:0]       YEAR_OFS_HI = 16'd4715;

    // Load strobes for the two register ranks of a constant divider.
    typedef struct packed {
        logic a;
        logic b;
    } cdiv_ld_t;

    // floor(30.6001 * e): days before the month indexed by e.
    function automatic logic [BD_W-1:0] month_span(input logic [E_W-1:0] e);
        logic [BD_W-1:0] span;
        begin
            case (e)
                5'd4:    span = 9'd122;
                5'd5:    span = 9'd153;
                5'd6:    span = 9'd183;
                5'd7:    span = 9'd214;
                5'd8:    span = 9'd244;
                5'd9:    span = 9'd275;
                5'd10:   span = 9'd306;
                5'd11:   span = 9'd336;
                5'd12:   span = 9'd367;
                5'd13:   span = 9'd397;
                5'd14:   span = 9'd428;
                5'd15:   span = 9'd459;
                default: span = 9'd0;
            endcase
            return span;
        end
    endfunction

endpackage

[rtl/dn2cd_cdiv.sv]
// Two-rank divider by a constant: reciprocal estimate, then one-step remainder correction.
module dn2cd_cdiv
    import dn2cd_pkg::*;
#(
    parameter int XW  = 24,
    parameter int QW  = 7,
    parameter int DIV = 146097,
    parameter int SH  = 24
)
(
    input  logic          clk,
    input  cdiv_ld_t      ld,
    input  logic [XW-1:0] x,
    output logic [QW-1:0] q
);

    // 2^SH exceeds every dividend, so the estimate is low by at most one.
    localparam longint unsigned RECIP = (64'd1 << SH) / DIV;
    localparam int              MW    = $clog2(RECIP + 1);

    logic [XW+MW-1:0] prod;
    logic [QW-1:0]    qe_next;
    logic [QW-1:0]    qe_reg;
    logic [XW-1:0]    x_reg;
    logic [XW-1:0]    rem;
    logic [QW-1:0]    q_next;
    logic [QW-1:0]    q_reg;

    assign prod    = (XW+MW)'(x) * (XW+MW)'(RECIP);
    assign qe_next = QW'(prod >> SH);

    assign rem     = x_reg - XW'(XW'(qe_reg) * XW'(DIV));
    assign q_next  = (rem >= XW'(DIV)) ? qe_reg + QW'(1) : qe_reg;

    always_ff @(posedge clk)
    begin
        if (ld.a)
        begin
            x_reg  <= x;
            qe_reg <= qe_next;
        end
        if (ld.b)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[rtl/day_number_to_calendar_date.sv]
// Day number (JDN minus one) to calendar date converter, top level.
//
// Slave stream s_axis carries one day number per transaction; master stream
// m_axis returns the calendar date (year, month, day) of that day. Julian
// calendar applies before JDN 2299161, Gregorian from then on; day numbers
// beyond 31 December 9999 saturate to that date.
//
// The datapath is an 11-stage register pipeline: three constant dividers
// (two ranks each) plus input, scaling and output ranks. Throughput is one
// transaction per cycle while m_axis_tready stays high, since every stage
// then advances; a receiver stall holds the pipeline.
//
// Each stage has its own valid bit and accepts data when empty or when the
// stage after it moves, so bubbles close up while the receiver stalls and
// s_axis_tready drops only once all 11 stages hold data. Nothing is lost or
// repeated under a stall. Reset (rst_n low) empties all stages; payload
// registers are not reset.
module day_number_to_calendar_date
    import dn2cd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [22:0] day_number, [23] zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [14:0] cal_year, [18:15] cal_month, [23:19] cal_day
);

    localparam int NST = 11;

    logic [NST:1]   v_reg;
    logic [NST:1]   v_next;
    logic [NST+1:1] rdy;

    always_comb
    begin
        rdy[NST+1] = m_axis_tready;
        for (int k = NST; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[1] = rdy[1] ? s_axis_tvalid : v_reg[1];
        for (int k = 2; k <= NST; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Stage 1: saturate, offset, calendar select
    logic [DN_W-1:0] dn;
    logic [Z_W-1:0]  z_next;
    logic            g_next;
    logic [XA_W-1:0] xa_next;
    logic [Z_W-1:0]  z1_reg;
    logic            g1_reg;
    logic [XA_W-1:0] xa1_reg;

    assign dn      = (s_axis_tdata[DN_W-1:0] > DAY_NUMBER_MAX) ? DAY_NUMBER_MAX
                                                              : s_axis_tdata[DN_W-1:0];
    assign z_next  = Z_W'(dn) + Z_W'(1);
    assign g_next  = (z_next >= GREGORIAN_START);
    assign xa_next = {z_next[XA_W-3:0], 2'b00} - ALPHA_BIAS;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            z1_reg  <= z_next;
            g1_reg  <= g_next;
            xa1_reg <= xa_next;
        end
    end

    // Stages 2-3: alpha
    logic [ALPHA_W-1:0] alpha;
    logic [Z_W-1:0]     z2_reg;
    logic [Z_W-1:0]     z3_reg;
    logic               g2_reg;
    logic               g3_reg;

    dn2cd_cdiv #(
        .XW  (XA_W),
        .QW  (ALPHA_W),
        .DIV (ALPHA_DIV),
        .SH  (XA_W)
    ) u_div_alpha (
        .clk (clk),
        .ld  ('{a: rdy[2], b: rdy[3]}),
        .x   (xa1_reg),
        .q   (alpha)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            z2_reg <= z1_reg;
            g2_reg <= g1_reg;
        end
        if (rdy[3])
        begin
            z3_reg <= z2_reg;
            g3_reg <= g2_reg;
        end
    end

    // Stage 4: b and scaled dividend for c
    logic [B_W-1:0]  a_val;
    logic [B_W-1:0]  b_next;
    logic [XC_W-1:0] xc_next;
    logic [B_W-1:0]  b4_reg;
    logic [XC_W-1:0] xc4_reg;

    assign a_val   = g3_reg ? z3_reg + B_W'(1) + B_W'(alpha) - B_W'(alpha >> 2) : z3_reg;
    assign b_next  = a_val + B_OFFSET;
    assign xc_next = {b_next, 4'b0000} + {2'b00, b_next, 2'b00} - XC_BIAS;

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            b4_reg  <= b_next;
            xc4_reg <= xc_next;
        end
    end

    // Stages 5-6: c
    logic [C_W-1:0] c_q;
    logic [B_W-1:0] b5_reg;
    logic [B_W-1:0] b6_reg;

    dn2cd_cdiv #(
        .XW  (XC_W),
        .QW  (C_W),
        .DIV (C_DIV),
        .SH  (XC_W)
    ) u_div_c (
        .clk (clk),
        .ld  ('{a: rdy[5], b: rdy[6]}),
        .x   (xc4_reg),
        .q   (c_q)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            b5_reg <= b4_reg;
        end
        if (rdy[6])
        begin
            b6_reg <= b5_reg;
        end
    end

    // Stage 7: d and b - d
    logic [C_W+10:0] d4;
    logic [BD_W-1:0] bd_next;
    logic [C_W-1:0]  c7_reg;
    logic [BD_W-1:0] bd7_reg;

    assign d4      = (C_W+11)'(c_q) * (C_W+11)'(DAYS_4Y);
    assign bd_next = BD_W'(b6_reg - B_W'(d4 >> 2));

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            c7_reg  <= c_q;
            bd7_reg <= bd_next;
        end
    end

    // Stage 8: scaled dividend for e
    logic [XE_W-1:0] xe_next;
    logic [C_W-1:0]  c8_reg;
    logic [BD_W-1:0] bd8_reg;
    logic [XE_W-1:0] xe8_reg;

    assign xe_next = XE_W'(bd7_reg) * XE_W'(E_SCALE);

    always_ff @(posedge clk)
    begin
        if (rdy[8])
        begin
            c8_reg  <= c7_reg;
            bd8_reg <= bd7_reg;
            xe8_reg <= xe_next;
        end
    end

    // Stages 9-10: e
    logic [E_W-1:0]  e_q;
    logic [C_W-1:0]  c9_reg;
    logic [C_W-1:0]  c10_reg;
    logic [BD_W-1:0] bd9_reg;
    logic [BD_W-1:0] bd10_reg;

    dn2cd_cdiv #(
        .XW  (XE_W),
        .QW  (E_W),
        .DIV (E_DIV),
        .SH  (XE_W)
    ) u_div_e (
        .clk (clk),
        .ld  ('{a: rdy[9], b: rdy[10]}),
        .x   (xe8_reg),
        .q   (e_q)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[9])
        begin
            c9_reg  <= c8_reg;
            bd9_reg <= bd8_reg;
        end
        if (rdy[10])
        begin
            c10_reg  <= c9_reg;
            bd10_reg <= bd9_reg;
        end
    end

    // Stage 11: day, month, year
    logic [DAY_W-1:0]          day_next;
    logic [MONTH_W-1:0]        month_next;
    logic signed [YEAR_W-1:0]  year_next;
    logic [DAY_W-1:0]          day_reg;
    logic [MONTH_W-1:0]        month_reg;
    logic signed [YEAR_W-1:0]  year_reg;

    assign day_next   = DAY_W'(bd10_reg - month_span(e_q));
    assign month_next = (e_q < E_YEAR_WRAP) ? MONTH_W'(e_q - E_W'(1))
                                            : MONTH_W'(e_q - E_W'(13));
    assign year_next  = YEAR_W'({1'b0, c10_reg} -
                                ((month_next > FEBRUARY) ? YEAR_OFS_LO : YEAR_OFS_HI));

    always_ff @(posedge clk)
    begin
        if (rdy[11])
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
        end
    end

    assign s_axis_tready = rdy[1];
    assign m_axis_tvalid = v_reg[NST];
    assign m_axis_tdata  = {day_reg, month_reg, year_reg};

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (month_reg >= 4'd1) && (month_reg <= 4'd12))
        else $error("cal_month out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (day_reg >= 5'd1))
        else $error("cal_day is zero");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (year_reg >= -15'sd4712) && (year_reg <= 15'sd9999))
        else $error("cal_year out of range");

    a_full_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&v_reg))
        else $error("input stalled with an empty stage");

    a_stall_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready && !s_axis_tvalid) |=>
            ($countones(v_reg) == $countones($past(v_reg))))
        else $error("transaction lost or duplicated in pipeline");

endmodule
